[design/epcrw_pkg.sv]
`timescale 1ns / 1ps

package epcrw_pkg;

    localparam int COUNT_W = 16;
    localparam int TIME_W  = 32;
    localparam int PPR_W   = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Scale from pulses per microsecond window to rpm: 60 s/min * 1e6 us/s
    localparam int SCALE_W = 27;
    localparam logic signed [SCALE_W-1:0] RPM_SCALE = 27'sd60000000;

    // Divisor is pulses_per_rev times a positive 31-bit span
    localparam int DEN_W = PPR_W + TIME_W - 1;
    // Quotient bits developed by the divider; larger values saturate anyway
    localparam int Q_W = 17;
    localparam int DIV_STEPS = Q_W;
    localparam int CMP_W = DEN_W + Q_W;

    localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_INVERT = 1'd1;

    localparam logic signed [COUNT_W-1:0] RPM_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] RPM_MIN = 16'sh8000;

    localparam int PC_W = 3;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_OLD,
        OP_SPAN,
        OP_SUM,
        OP_MUL,
        OP_PREP,
        OP_DIV,
        OP_FIN
    } uop_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_START,
        JMP_LOOP,
        JMP_WAIT
    } jmp_t;

    typedef enum logic [1:0] {
        LD_NONE,
        LD_SUM,
        LD_DIV
    } ld_t;

    typedef struct packed {
        uop_t             op;
        ld_t              load;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } uword_t;

    // Handshake between sequencer and datapath
    typedef struct packed {
        logic start;     // sample transfer accepted
        logic out_free;  // output register can take a result
    } seq_stat_t;

endpackage

[design/epcrw_seq.sv]
`timescale 1ns / 1ps

module epcrw_seq
    import epcrw_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output uop_t      op
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + DIV_STEPS);

    logic [PC_W-1:0]  pc_reg;
    logic [PC_W-1:0]  pc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    uword_t           uw;

    // Microprogram for one sample
    function automatic uword_t rom(input logic [PC_W-1:0] addr);
        uword_t w;
        case (addr)
            3'd0:    w = '{op: OP_IDLE, load: LD_NONE, jmp: JMP_START, target: 3'd1};
            3'd1:    w = '{op: OP_OLD,  load: LD_NONE, jmp: JMP_NEXT,  target: 3'd0};
            3'd2:    w = '{op: OP_SPAN, load: LD_SUM,  jmp: JMP_NEXT,  target: 3'd0};
            3'd3:    w = '{op: OP_SUM,  load: LD_NONE, jmp: JMP_LOOP,  target: 3'd0};
            3'd4:    w = '{op: OP_MUL,  load: LD_NONE, jmp: JMP_NEXT,  target: 3'd0};
            3'd5:    w = '{op: OP_PREP, load: LD_DIV,  jmp: JMP_NEXT,  target: 3'd0};
            3'd6:    w = '{op: OP_DIV,  load: LD_NONE, jmp: JMP_LOOP,  target: 3'd0};
            3'd7:    w = '{op: OP_FIN,  load: LD_NONE, jmp: JMP_WAIT,  target: 3'd0};
            default: w = '{op: OP_IDLE, load: LD_NONE, jmp: JMP_START, target: 3'd1};
        endcase
        return w;
    endfunction

    assign uw = rom(pc_reg);
    assign op = uw.op;

    always_comb
    begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        case (uw.jmp)
            JMP_NEXT:
            begin
                pc_next = pc_reg + 1'b1;
            end
            JMP_START:
            begin
                if (stat.start)
                begin
                    pc_next = uw.target;
                end
            end
            JMP_LOOP:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            JMP_WAIT:
            begin
                if (stat.out_free)
                begin
                    pc_next = uw.target;
                end
            end
            default:
            begin
                pc_next = '0;
            end
        endcase
        case (uw.load)
            LD_SUM:  cnt_next = CNT_W'(HISTORY_DEPTH - 2);
            LD_DIV:  cnt_next = CNT_W'(DIV_STEPS - 1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/epcrw_hist.sv]
`timescale 1ns / 1ps

module epcrw_hist
    import epcrw_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
    input  logic [COUNT_W-1:0]               wcount,
    input  logic [TIME_W-1:0]                wtime,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
    output logic [COUNT_W-1:0]               rcount,
    output logic [TIME_W-1:0]                rtime
);

    logic [COUNT_W-1:0]       count_mem [HISTORY_DEPTH];
    logic [TIME_W-1:0]        time_mem  [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic                     rvalid_reg;
    logic [COUNT_W-1:0]       rcount_reg;
    logic [TIME_W-1:0]        rtime_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            count_mem[waddr] <= wcount;
            time_mem[waddr]  <= wtime;
        end
        rcount_reg <= count_mem[raddr];
        rtime_reg  <= time_mem[raddr];
    end

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rcount = rvalid_reg ? rcount_reg : '0;
    assign rtime  = rvalid_reg ? rtime_reg  : '0;

endmodule

[design/epcrw_dp.sv]
`timescale 1ns / 1ps

module epcrw_dp
    import epcrw_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  uop_t                        op,
    input  logic                        in_xfer,
    input  logic [MODE_W-1:0]           mode,
    input  logic                        dir_level,
    input  logic [TIME_W-1:0]           timestamp_us,
    input  logic [PPR_W-1:0]            pulses_per_rev,
    input  logic                        direction_invert,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic signed [COUNT_W-1:0]   interval_count,
    output logic signed [COUNT_W-1:0]   speed_rpm,
    output seq_stat_t                   stat
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int SUM_W = COUNT_W + AW;
    localparam int PROD_W = SUM_W + SCALE_W;
    localparam int NUM_W = SUM_W + SCALE_W - 1;

    logic [COUNT_W-1:0]       pulse_count_reg;
    logic [AW-1:0]            wslot_reg;
    logic [AW-1:0]            wslot_inc;
    logic [AW-1:0]            rptr_reg;
    logic [AW-1:0]            rptr_inc;
    logic [COUNT_W-1:0]       taken_reg;
    logic [TIME_W-1:0]        ts_reg;
    logic [TIME_W-1:0]        span_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     zero_reg;
    logic                     neg_reg;
    logic                     sat_reg;
    logic [CMP_W-1:0]         rem_reg;
    logic [CMP_W-1:0]         dsh_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     out_valid_reg;
    logic [COUNT_W-1:0]       icount_reg;
    logic [COUNT_W-1:0]       rpm_reg;

    logic                     sample_xfer;
    logic [COUNT_W-1:0]       rcount;
    logic [TIME_W-1:0]        rtime;
    logic [PROD_W-1:0]        prod_abs;
    logic [CMP_W-1:0]         mag;
    logic [Q_W-1:0]           q_neg;
    logic [COUNT_W-1:0]       rpm_next;

    assign sample_xfer = in_xfer && (mode == MODE_SAMPLE);
    assign wslot_inc = (wslot_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_reg + 1'b1;
    assign rptr_inc  = (rptr_reg  == AW'(HISTORY_DEPTH - 1)) ? '0 : rptr_reg  + 1'b1;

    epcrw_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (sample_xfer),
        .waddr  (wslot_reg),
        .wcount (pulse_count_reg),
        .wtime  (timestamp_us),
        .raddr  (rptr_reg),
        .rcount (rcount),
        .rtime  (rtime)
    );

    assign prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign mag      = CMP_W'(prod_abs[NUM_W-1:0]);
    assign q_neg    = Q_W'(~q_reg + 1'b1);

    always_comb
    begin
        if (zero_reg)
        begin
            rpm_next = '0;
        end
        else if (neg_reg)
        begin
            rpm_next = (sat_reg || (q_reg > Q_W'(32768))) ? RPM_MIN : q_neg[COUNT_W-1:0];
        end
        else
        begin
            rpm_next = (sat_reg || (q_reg > Q_W'(32767))) ? RPM_MAX : q_reg[COUNT_W-1:0];
        end
    end

    assign stat.start    = sample_xfer;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg <= '0;
            wslot_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                case (mode)
                    MODE_PULSE:
                    begin
                        if (dir_level != direction_invert)
                        begin
                            pulse_count_reg <= pulse_count_reg + 1'b1;
                        end
                        else
                        begin
                            pulse_count_reg <= pulse_count_reg - 1'b1;
                        end
                    end
                    MODE_SAMPLE:
                    begin
                        pulse_count_reg <= '0;
                        wslot_reg       <= wslot_inc;
                    end
                    MODE_CLEAR:
                    begin
                        pulse_count_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (op == OP_FIN && stat.out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers steered by the current microinstruction
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            taken_reg <= pulse_count_reg;
            ts_reg    <= timestamp_us;
            rptr_reg  <= wslot_inc;
        end
        case (op)
            OP_OLD:
            begin
                rptr_reg <= rptr_inc;
            end
            OP_SPAN:
            begin
                span_reg <= ts_reg - rtime;
                sum_reg  <= '0;
                rptr_reg <= rptr_inc;
            end
            OP_SUM:
            begin
                sum_reg  <= sum_reg + SUM_W'(signed'(rcount));
                rptr_reg <= rptr_inc;
            end
            OP_MUL:
            begin
                prod_reg <= PROD_W'(sum_reg) * PROD_W'(RPM_SCALE);
                den_reg  <= DEN_W'(pulses_per_rev) * DEN_W'(span_reg[TIME_W-2:0]);
                zero_reg <= span_reg[TIME_W-1] || (span_reg == '0) || (pulses_per_rev == '0);
            end
            OP_PREP:
            begin
                neg_reg <= prod_reg[PROD_W-1];
                rem_reg <= mag;
                sat_reg <= mag >= {den_reg, {Q_W{1'b0}}};
                dsh_reg <= {1'b0, den_reg, {(Q_W-1){1'b0}}};
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_FIN:
            begin
                if (stat.out_free)
                begin
                    icount_reg <= taken_reg;
                    rpm_reg    <= rpm_next;
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign interval_count = signed'(icount_reg);
    assign speed_rpm      = signed'(rpm_reg);

endmodule

[design/encoder_pulse_count_rpm_window.sv]
`timescale 1ns / 1ps

// Pulse/direction encoder speed meter. A pulse transfer (mode 0) moves a
// wrapping signed 16-bit count up when dir_level differs from
// direction_invert and down otherwise; a clear transfer (mode 2) zeroes it;
// both give no result, and the next transfer may follow at once. A sample
// transfer (mode 1) stores the count and timestamp_us in a ring of
// HISTORY_DEPTH slots, zeroes the count and yields one result:
// interval_count is the count taken, speed_rpm is the sum of the ring
// without its oldest slot times 60e6 over pulses_per_rev times the
// oldest-to-newest microsecond span, truncated toward zero and saturated to
// int16, or zero when the span is not positive or pulses_per_rev is zero.
// A sample keeps in_ready low until its result is registered, which waits
// while out_ready holds off a previous result: the window sum walks the
// history memory through its single read port one slot per cycle, and the
// divider develops one quotient bit per cycle over 17 steps, all under a
// small microprogram. The result sits in an output register, so new pulses
// are taken while it waits. The ring reads as zero until written. Write
// pulses_per_rev and direction_invert only while no sample is in flight.
module encoder_pulse_count_rpm_window
    import epcrw_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_IDX_W-1:0]       wr_index,
    input  logic [CFG_DATA_W-1:0]      wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MODE_W-1:0]          mode,
    input  logic                       dir_level,
    input  logic [TIME_W-1:0]          timestamp_us,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COUNT_W-1:0]  interval_count,
    output logic signed [COUNT_W-1:0]  speed_rpm
);

    logic [PPR_W-1:0] pulses_per_rev_reg;
    logic             direction_invert_reg;
    uop_t             op;
    seq_stat_t        stat;
    logic             in_xfer;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulses_per_rev_reg   <= PPR_W'(20);
            direction_invert_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PULSES_PER_REV:   pulses_per_rev_reg   <= wr_data[PPR_W-1:0];
                REG_DIRECTION_INVERT: direction_invert_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // Take input only while the microprogram sits at its idle step
    assign in_ready = (op == OP_IDLE);
    assign in_xfer  = in_valid && in_ready;

    epcrw_seq #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    epcrw_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .in_xfer          (in_xfer),
        .mode             (mode),
        .dir_level        (dir_level),
        .timestamp_us     (timestamp_us),
        .pulses_per_rev   (pulses_per_rev_reg),
        .direction_invert (direction_invert_reg),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .interval_count   (interval_count),
        .speed_rpm        (speed_rpm),
        .stat             (stat)
    );

endmodule

[design/epcrw_chk.sv]
`timescale 1ns / 1ps

module epcrw_chk
    import epcrw_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      wr_en,
    input logic [CFG_IDX_W-1:0]      wr_index,
    input logic [CFG_DATA_W-1:0]     wr_data,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [MODE_W-1:0]         mode,
    input logic                      dir_level,
    input logic [TIME_W-1:0]         timestamp_us,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COUNT_W-1:0] interval_count,
    input logic signed [COUNT_W-1:0] speed_rpm
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(interval_count) && $stable(speed_rpm))
        else $error("result changed while stalled");

    // A sample transfer starts the microprogram and blocks input
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == MODE_SAMPLE |=> !in_ready)
        else $error("input not blocked after sample");

    // Pulse, clear and reserved-mode transfers leave input ready on the next cycle
    a_pulse_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode != MODE_SAMPLE |=> in_ready)
        else $error("input blocked after pulse or clear");

    // A new result only leaves a running sample
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a sample in progress");

endmodule

bind encoder_pulse_count_rpm_window epcrw_chk u_chk (.*);

[tb/encoder_pulse_count_rpm_window_test.sv]
`timescale 1ns / 1ps

module encoder_pulse_count_rpm_window_test;
    import epcrw_pkg::*;

    localparam int HISTORY_DEPTH = 8;
    // Reserved mode code; the block must drop such a transfer silently.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Leave margin on top of the time a sample holds the input.
    localparam int SETTLE_CYCLES = HISTORY_DEPTH + 40;
    localparam int RECEIVER_HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [COUNT_W-1:0] interval_count;
        logic signed [COUNT_W-1:0] speed_rpm;
    } sample_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       wr_en;
    logic [CFG_IDX_W-1:0]       wr_index;
    logic [CFG_DATA_W-1:0]      wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [MODE_W-1:0]          mode;
    logic                       dir_level;
    logic [TIME_W-1:0]          timestamp_us;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [COUNT_W-1:0]  interval_count;
    logic signed [COUNT_W-1:0]  speed_rpm;

    // Shadow of the block: register settings, running count and the history ring.
    logic [PPR_W-1:0]           ppr_setting;
    logic                       invert_setting;
    logic signed [COUNT_W-1:0]  running_count;
    logic signed [COUNT_W-1:0]  ring_count [HISTORY_DEPTH];
    logic [TIME_W-1:0]          ring_time [HISTORY_DEPTH];
    int unsigned                ring_slot;

    // Results still owed by the block, oldest first.
    sample_result_t             pending_results [$];

    int                         fault_count = 0;
    int                         hold_requests = 0;
    int                         burst_left = 0;
    int                         cycle_count = 0;

    encoder_pulse_count_rpm_window #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .dir_level      (dir_level),
        .timestamp_us   (timestamp_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .interval_count (interval_count),
        .speed_rpm      (speed_rpm)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs somewhere.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Rpm over the ring: sum of every slot but the oldest, times 60e6, over
    // pulses_per_rev times the signed oldest-to-newest span. Truncate toward
    // zero, then clamp to int16. A span that is not positive gives zero.
    function automatic logic signed [COUNT_W-1:0] speed_over_ring();
        longint                    pulse_sum;
        longint                    numer;
        longint                    denom;
        longint                    quot;
        logic signed [TIME_W-1:0]  span_us;
        int unsigned               newest;
        int                        i;
        pulse_sum = 0;
        newest = (ring_slot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
        span_us = ring_time[newest] - ring_time[ring_slot];
        if (span_us <= 0 || ppr_setting == '0)
            return '0;
        for (i = 0; i < HISTORY_DEPTH; i++)
            if (i != ring_slot)
                pulse_sum += ring_count[i];
        numer = pulse_sum * longint'(RPM_SCALE);
        denom = longint'(ppr_setting) * longint'(span_us);
        quot = numer / denom;
        if (quot > longint'(RPM_MAX))
            return RPM_MAX;
        if (quot < longint'(RPM_MIN))
            return RPM_MIN;
        return quot[COUNT_W-1:0];
    endfunction

    // Apply one accepted transfer to the shadow state; queue the result a
    // sample owes.
    task automatic take_transfer(input logic [MODE_W-1:0] m, input logic d,
                                 input logic [TIME_W-1:0] ts);
        sample_result_t owed;
        case (m)
            MODE_PULSE:
            begin
                if (d != invert_setting)
                    running_count = running_count + 16'sd1;
                else
                    running_count = running_count - 16'sd1;
            end
            MODE_CLEAR:
                running_count = '0;
            MODE_SAMPLE:
            begin
                owed.interval_count = running_count;
                ring_count[ring_slot] = running_count;
                ring_time[ring_slot] = ts;
                ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
                running_count = '0;
                owed.speed_rpm = speed_over_ring();
                pending_results.push_back(owed);
            end
            default:
                ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one transfer and hold it until the block takes it.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic d,
                             input logic [TIME_W-1:0] ts);
        in_valid     <= 1'b1;
        mode         <= m;
        dir_level    <= d;
        timestamp_us <= ts;
        do
            @(posedge clk);
        while (!in_ready);
        take_transfer(m, d, ts);
    endtask

    task automatic send_pulses(input int count, input logic d);
        int k;
        for (k = 0; k < count; k++)
            send_item(MODE_PULSE, d, $urandom);
    endtask

    // Bursts of random length with idle gaps between some of them; valid drops
    // only for a nonzero gap so it never drops and rises in the same step.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 30);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, wait for every owed result, then let the block settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        if (idx == REG_PULSES_PER_REV)
            ppr_setting = value[PPR_W-1:0];
        else
            invert_setting = value[0];
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [PPR_W-1:0] ppr, input logic inv);
        quiesce();
        write_reg(REG_PULSES_PER_REV, ppr);
        write_reg(REG_DIRECTION_INVERT, {{(CFG_DATA_W-1){1'b0}}, inv});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: empty ring, zero and wrapped spans, negative counts,
    // clear, the reserved mode, saturation low and the widest positive span.
    task automatic test_directed_extremes();
        send_item(MODE_SAMPLE, 1'b0, 32'd0);
        send_pulses(3, 1'b1);
        send_pulses(1, 1'b0);
        send_item(MODE_SAMPLE, 1'b1, 32'd1000);
        send_pulses(6, 1'b0);
        send_item(MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF);
        send_pulses(1, 1'b1);
        send_item(MODE_CLEAR, 1'b1, 32'hFFFF_FFFF);
        send_item(MODE_UNUSED, 1'b1, 32'h5555_AAAA);
        send_item(MODE_SAMPLE, 1'b1, 32'h8000_0000);
        send_pulses(3, 1'b0);
        send_item(MODE_SAMPLE, 1'b0, 32'd1);
        send_pulses(1, 1'b1);
        send_item(MODE_SAMPLE, 1'b1, 32'h7FFF_FFFF);
    endtask

    // Register extremes: one pulse per rev with inverted direction, then the
    // largest divisor with normal direction.
    task automatic test_register_extremes();
        logic [TIME_W-1:0] t_us;
        t_us = 32'h8000_0100;
        apply_settings(16'd1, 1'b1);
        send_pulses(4, 1'b0);
        send_pulses(1, 1'b1);
        send_item(MODE_SAMPLE, 1'b0, t_us);
        send_pulses(2, 1'b0);
        send_item(MODE_SAMPLE, 1'b1, t_us + 32'd500);
        apply_settings(16'hFFFF, 1'b0);
        send_pulses(5, 1'b1);
        send_item(MODE_SAMPLE, 1'b0, t_us + 32'd900);
        send_pulses(2, 1'b0);
        send_item(MODE_SAMPLE, 1'b1, t_us + 32'd20000);
    endtask

    // One random phase: mostly pulses with a per-phase direction bias and
    // samples on a rising clock, plus a little noise (out-of-order times,
    // clears, reserved mode).
    task automatic run_random_phase(input int n_items, input logic [PPR_W-1:0] ppr,
                                    input logic inv);
        logic [TIME_W-1:0] clock_us;
        logic [TIME_W-1:0] ts;
        int                up_pct;
        int                roll;
        int                k;
        logic              want_up;
        apply_settings(ppr, inv);
        up_pct = $urandom_range(0, 100);
        // Start anywhere, sometimes just short of the 32-bit wrap.
        clock_us = ($urandom_range(0, 1) == 0) ? $urandom
                   : 32'hFFFF_FFFF - $urandom_range(0, 100000);
        for (k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
            begin
                want_up = ($urandom_range(0, 99) < up_pct);
                send_item(MODE_PULSE, want_up ? ~invert_setting : invert_setting, $urandom);
            end
            else if (roll < 93)
            begin
                case ($urandom_range(0, 9))
                    0:       clock_us = clock_us + $urandom_range(1, 20);
                    1, 2, 3,
                    4, 5:    clock_us = clock_us + $urandom_range(100, 20000);
                    6, 7, 8: clock_us = clock_us + $urandom_range(20000, 3000000);
                    default: ;
                endcase
                ts = ($urandom_range(0, 19) == 0) ? $urandom : clock_us;
                send_item(MODE_SAMPLE, 1'($urandom_range(0, 1)), ts);
            end
            else if (roll < 97)
                send_item(MODE_CLEAR, 1'($urandom_range(0, 1)), $urandom);
            else
                send_item(MODE_UNUSED, 1'($urandom_range(0, 1)), $urandom);
            pace_sender();
        end
    endtask

    task automatic test_random_phases();
        run_random_phase(140, 16'd20, 1'b0);
        run_random_phase(140, 16'd1, 1'b1);
        run_random_phase(140, 16'hFFFF, 1'b0);
        run_random_phase(140, PPR_W'($urandom_range(1, 65535)), 1'b1);
        run_random_phase(140, 16'd360, 1'b0);
        run_random_phase(140, PPR_W'($urandom_range(1, 4096)), 1'($urandom_range(0, 1)));
    endtask

    // Hold the receiver off for a long stretch while transfers keep coming
    // back to back, so the output register fills and the input stalls.
    task automatic test_output_backpressure();
        logic [TIME_W-1:0] clock_us;
        int                k;
        apply_settings(16'd100, 1'b0);
        clock_us = $urandom;
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 60; k++)
        begin
            if (k % 6 == 5)
            begin
                clock_us = clock_us + $urandom_range(50, 5000);
                send_item(MODE_SAMPLE, 1'($urandom_range(0, 1)), clock_us);
            end
            else
                send_item(MODE_PULSE, $urandom_range(0, 3) != 0, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall patterns plus an occasional long hold
    // ------------------------------------------------------------------
    initial
    begin
        int stall_pct;
        int stretch;
        int hold_left;
        int hold_served;
        stall_pct = 0;
        stretch = 0;
        hold_left = 0;
        hold_served = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = RECEIVER_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch = $urandom_range(5, 60);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                stretch--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each transfer out with the oldest owed result
    // ------------------------------------------------------------------
    task automatic note_fault(input string what, input int want, input int got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0d, got %0d",
                     cycle_count, what, want, got);
    endtask

    initial
    begin
        sample_result_t owed;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    note_fault("unexpected result, interval_count", 0, interval_count);
                else
                begin
                    owed = pending_results.pop_front();
                    if (interval_count !== owed.interval_count)
                        note_fault("interval_count", owed.interval_count, interval_count);
                    if (speed_rpm !== owed.speed_rpm)
                        note_fault("speed_rpm", owed.speed_rpm, speed_rpm);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        // Shadow state matches the block after reset.
        ppr_setting = 16'd20;
        invert_setting = 1'b0;
        running_count = '0;
        ring_slot = 0;
        for (i = 0; i < HISTORY_DEPTH; i++)
        begin
            ring_count[i] = '0;
            ring_time[i] = '0;
        end
        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= REG_PULSES_PER_REV;
        wr_data      <= '0;
        in_valid     <= 1'b0;
        mode         <= MODE_PULSE;
        dir_level    <= 1'b0;
        timestamp_us <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_register_extremes();
        test_random_phases();
        test_output_backpressure();

        // Drain whatever is still owed, then give the block time to show
        // any stray result.
        quiesce();
        if (fault_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
